@@ rtl/smt_pkg.sv @@
// shared types and codes for the sorted method table
// no dependencies; smt_ctrl and sorted_method_table_unit refer to it by scoped names
package smt_pkg;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_INSERT = 2'd2;
    localparam logic [1:0] FUNC_LOOKUP = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] address_value;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] result_address;
        logic [5:0]  result_index;
        logic [6:0]  entry_count;
        logic        table_full;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

@@ rtl/smt_mem.sv @@
// entry memory of the sorted method table: one write port, one registered read port
// no package dependencies
module smt_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/smt_ctrl.sv @@
// sequencer of the sorted method table: scan, shift, update and result register
// depends on smt_pkg and drives the ports of smt_mem
module smt_ctrl #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  smt_pkg::in_item_t            req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output smt_pkg::out_item_t           rsp,
    output logic                         mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]     mem_wr_addr,
    output logic [KEY_WIDTH+31:0]        mem_wr_data,
    output logic                         mem_rd_en,
    output logic [$clog2(DEPTH)-1:0]     mem_rd_addr,
    input  logic [KEY_WIDTH+31:0]        mem_rd_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    smt_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [1:0]           func_reg, func_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [31:0]          addr_reg, addr_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [31:0]          entry0_reg, entry0_next;
    logic [IDX_W-1:0]     sh_rd_reg, sh_rd_next;
    logic [IDX_W-1:0]     sh_wr_reg, sh_wr_next;
    logic                 sh_more_reg, sh_more_next;
    logic                 sh_pend_reg, sh_pend_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic                 res_found_reg, res_found_next;
    logic [31:0]          res_addr_reg, res_addr_next;
    logic [CNT_W-1:0]     res_idx_reg, res_idx_next;
    logic                 res_full_reg, res_full_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    smt_pkg::out_item_t   rsp_reg, rsp_next;

    logic                 accept;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [31:0]          rd_addr_val;
    logic                 hit;
    logic                 scan_stop;
    logic [CNT_W-1:0]     stop_idx;
    logic                 key_eq;
    logic                 rsp_load;
    logic                 shift_end;

    assign req_stall   = (state_reg != smt_pkg::ST_IDLE);
    assign accept      = req_valid && !req_stall;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;
    assign count       = count_reg;
    assign rd_key      = mem_rd_data[KEY_WIDTH+31:32];
    assign rd_addr_val = mem_rd_data[31:0];
    assign rsp_load    = !rsp_valid_reg || !rsp_stall;
    assign shift_end   = !sh_more_reg && !sh_pend_reg;

    // compare stage of the streaming scan
    always_comb
    begin
        key_eq    = (rd_key == key_reg);
        hit       = 1'b0;
        scan_stop = 1'b0;
        stop_idx  = '0;
        if (count_reg == '0)
        begin
            scan_stop = 1'b1;
        end
        else if (cmp_vld_reg)
        begin
            if (func_reg == smt_pkg::FUNC_INSERT)
            begin
                hit = (rd_key >= key_reg);
            end
            else
            begin
                hit = key_eq;
            end
            if (hit)
            begin
                scan_stop = 1'b1;
                stop_idx  = CNT_W'(cmp_idx_reg);
            end
            else if (CNT_W'(cmp_idx_reg) == count_reg - ONE_CNT)
            begin
                scan_stop = 1'b1;
                stop_idx  = count_reg;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.func == smt_pkg::FUNC_INSERT || req.func == smt_pkg::FUNC_LOOKUP)
                    begin
                        state_next = smt_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = smt_pkg::ST_DONE;
                    end
                end
            end
            smt_pkg::ST_SCAN:
            begin
                if (scan_stop)
                begin
                    if (func_reg == smt_pkg::FUNC_INSERT && !(hit && key_eq)
                        && count_reg != FULL_CNT)
                    begin
                        state_next = smt_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        state_next = smt_pkg::ST_DONE;
                    end
                end
            end
            smt_pkg::ST_SHIFT:
            begin
                if (shift_end)
                begin
                    state_next = smt_pkg::ST_DONE;
                end
            end
            smt_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = smt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        addr_next      = addr_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        entry0_next    = entry0_reg;
        sh_rd_next     = sh_rd_reg;
        sh_wr_next     = sh_wr_reg;
        sh_more_next   = sh_more_reg;
        sh_pend_next   = 1'b0;
        pos_next       = pos_reg;
        res_found_next = res_found_reg;
        res_addr_next  = res_addr_reg;
        res_idx_next   = res_idx_reg;
        res_full_next  = res_full_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = {key_reg, addr_reg};
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;
        case (state_reg)
            smt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    func_next      = req.func;
                    key_next       = KEY_WIDTH'(req.key);
                    addr_next      = req.address_value;
                    rd_idx_next    = '0;
                    res_found_next = 1'b0;
                    res_addr_next  = '0;
                    res_idx_next   = '0;
                    res_full_next  = 1'b0;
                    case (req.func)
                        smt_pkg::FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        smt_pkg::FUNC_APPEND:
                        begin
                            res_idx_next = count_reg;
                            if (count_reg == FULL_CNT)
                            begin
                                res_full_next = 1'b1;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = count_reg[IDX_W-1:0];
                                mem_wr_data = {KEY_WIDTH'(req.key), req.address_value};
                                count_next  = count_reg + ONE_CNT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            smt_pkg::ST_SCAN:
            begin
                if (cmp_vld_reg && cmp_idx_reg == '0)
                begin
                    entry0_next = rd_addr_val;
                end
                // keep one read in flight ahead of the compare
                if (!scan_stop && rd_idx_reg < count_reg)
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = rd_idx_reg[IDX_W-1:0];
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + ONE_CNT;
                end
                if (scan_stop)
                begin
                    if (func_reg == smt_pkg::FUNC_INSERT)
                    begin
                        res_idx_next = stop_idx;
                        if (hit && key_eq)
                        begin
                            mem_wr_en      = 1'b1;
                            mem_wr_addr    = stop_idx[IDX_W-1:0];
                            res_found_next = 1'b1;
                        end
                        else if (count_reg == FULL_CNT)
                        begin
                            res_full_next = 1'b1;
                        end
                        else
                        begin
                            pos_next     = stop_idx;
                            sh_rd_next   = IDX_W'(count_reg - ONE_CNT);
                            sh_more_next = (stop_idx < count_reg);
                        end
                    end
                    else
                    begin
                        if (hit)
                        begin
                            res_found_next = 1'b1;
                            res_addr_next  = rd_addr_val;
                            res_idx_next   = stop_idx;
                        end
                        else if (count_reg != '0)
                        begin
                            // miss falls back to the first entry
                            res_addr_next = (cmp_idx_reg == '0) ? rd_addr_val : entry0_reg;
                        end
                    end
                end
            end
            smt_pkg::ST_SHIFT:
            begin
                // move entries up one slot, top entry first
                if (sh_pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = sh_wr_reg;
                    mem_wr_data = mem_rd_data;
                end
                if (sh_more_reg)
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = sh_rd_reg;
                    sh_wr_next   = sh_rd_reg + 1'b1;
                    sh_pend_next = 1'b1;
                    if (CNT_W'(sh_rd_reg) == pos_reg)
                    begin
                        sh_more_next = 1'b0;
                    end
                    else
                    begin
                        sh_rd_next = sh_rd_reg - 1'b1;
                    end
                end
                if (shift_end)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pos_reg[IDX_W-1:0];
                    count_next  = count_reg + ONE_CNT;
                end
            end
            smt_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.found          = res_found_reg;
                    rsp_next.result_address = res_addr_reg;
                    rsp_next.result_index   = 6'(res_idx_reg);
                    rsp_next.entry_count    = 7'(count_reg);
                    rsp_next.table_full     = res_full_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smt_pkg::ST_IDLE;
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            sh_more_reg   <= 1'b0;
            sh_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_vld_reg   <= cmp_vld_next;
            sh_more_reg   <= sh_more_next;
            sh_pend_reg   <= sh_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        key_reg       <= key_next;
        addr_reg      <= addr_next;
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        entry0_reg    <= entry0_next;
        sh_rd_reg     <= sh_rd_next;
        sh_wr_reg     <= sh_wr_next;
        pos_reg       <= pos_next;
        res_found_reg <= res_found_next;
        res_addr_reg  <= res_addr_next;
        res_idx_reg   <= res_idx_next;
        res_full_reg  <= res_full_next;
        rsp_reg       <= rsp_next;
    end

endmodule

@@ rtl/sorted_method_table_unit.sv @@
// sorted method table: key/address pairs in one memory, one item at a time
// clear and append: the transfer goes straight to the done state, which registers the result
// insert and lookup: the scan reads the entries in order, one per cycle;
// a new insert then moves the entries from its slot up one slot, top first, and writes itself there
// next transfer once back in idle; done waits while rsp_stall holds the result register
// reset clears the entry count and control state; memory contents stay undefined, no clearing pass
module sorted_method_table_unit #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  smt_pkg::in_item_t  req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output smt_pkg::out_item_t rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                  mem_wr_en;
    logic [IDX_W-1:0]      mem_wr_addr;
    logic [KEY_WIDTH+31:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [IDX_W-1:0]      mem_rd_addr;
    logic [KEY_WIDTH+31:0] mem_rd_data;
    logic [CNT_W-1:0]      count;

    smt_ctrl #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .count       (count)
    );

    smt_mem #(
        .DEPTH (DEPTH),
        .WIDTH (KEY_WIDTH + 32)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("transfer taken while an item is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.table_full) |-> (rsp.entry_count == 7'(DEPTH)))
        else $error("full flag with room left in the table");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.found) |-> !rsp.table_full)
        else $error("hit and full flag together");

endmodule
